// ===== rtl/tfsm_pkg.sv =====
// Package for the table-driven state machine engine.
// Holds sizes, item structs, the table entry layout, codes and controller states.
// No dependencies.
package tfsm_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int STATE_WIDTH = 8;
  localparam int TIME_WIDTH  = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 8;

  typedef logic [STATE_WIDTH-1:0] state_t;
  typedef logic [TIME_WIDTH-1:0]  tstamp_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_NO_MATCH = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_INITIAL_STATE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FAIL_STATE    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ENTRY_COUNT   = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  handler_code;
    logic [31:0] time_now_ms;
    logic [3:0]  slot;
    logic [7:0]  slot_from_state;
    logic [7:0]  slot_code;
    logic [7:0]  slot_to_state;
    logic [31:0] slot_timeout_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] state_after;
    logic       initial_entered;
    logic       changed;
    logic [7:0] left_state;
    logic [1:0] fail_cause;
  } out_item_t;

  typedef struct packed {
    state_t     from_state;
    logic [7:0] code;
    state_t     to_state;
    tstamp_t    timeout;
  } tbl_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DECIDE
  } ctl_state_t;

  typedef struct packed {
    logic load_go;
    logic tick_go;
    logic prep;
    logic scan;
    logic decide;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

// ===== rtl/tfsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tfsm_ctrl.sv =====
// Controller of the state machine engine: sequences accept, prepare, scan, decide.
// Depends on tfsm_pkg.
module tfsm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  opcode,
  input  tfsm_pkg::dp_status_t  status,
  output logic                  busy,
  output tfsm_pkg::ctl_cmd_t    cmd
);
  import tfsm_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && opcode == OP_TICK) state_nxt = ST_PREP;
      end
      ST_PREP:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_r != ST_IDLE);
    cmd         = '0;
    cmd.load_go = (state_r == ST_IDLE) && start && (opcode == OP_LOAD);
    cmd.tick_go = (state_r == ST_IDLE) && start && (opcode == OP_TICK);
    cmd.prep    = (state_r == ST_PREP);
    cmd.scan    = (state_r == ST_SCAN);
    cmd.decide  = (state_r == ST_DECIDE);
  end

endmodule

// ===== rtl/tfsm_dp.sv =====
// Datapath of the state machine engine: config registers, transition table,
// scan comparators, state and entry time, result register.
// Depends on tfsm_pkg and tfsm_ram.
module tfsm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tfsm_pkg::in_item_t             in_item,
  input  tfsm_pkg::ctl_cmd_t             cmd,
  output tfsm_pkg::dp_status_t           status,
  input  logic                           cfg_we,
  input  logic [tfsm_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [tfsm_pkg::CFG_DW-1:0]    cfg_wdata,
  output logic                           out_valid,
  output tfsm_pkg::out_item_t            out_item
);
  import tfsm_pkg::*;

  // configuration
  state_t      init_state_r;
  state_t      fail_state_r;
  logic [4:0]  entry_count_r;

  // machine state
  state_t      cur_state_r;
  tstamp_t     entry_time_r;
  logic        started_r;

  // per-tick working registers
  logic [7:0]  code_r;
  tstamp_t     now_r;
  tstamp_t     elapsed_r;
  logic        init_flag_r;
  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] addr_r;
  logic        rd_vld_r;
  logic        found_r;
  state_t      to_r;
  logic        tmo_hit_r;

  logic        out_valid_r;
  out_item_t   out_item_r;

  tbl_entry_t  wr_entry;
  tbl_entry_t  rd_entry;
  logic        tbl_we;
  logic        issue;
  logic        from_hit;

  state_t      dec_next;
  logic [1:0]  dec_cause;
  out_item_t   res_item;

  assign wr_entry.from_state = STATE_WIDTH'(in_item.slot_from_state);
  assign wr_entry.code       = in_item.slot_code;
  assign wr_entry.to_state   = STATE_WIDTH'(in_item.slot_to_state);
  assign wr_entry.timeout    = TIME_WIDTH'(in_item.slot_timeout_ms);
  assign tbl_we = cmd.load_go && (32'(in_item.slot) < MAX_ENTRIES);

  tfsm_ram #(
    .WIDTH ($bits(tbl_entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IDX_W'(in_item.slot)),
    .wdata (wr_entry),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  assign issue    = cmd.scan && (addr_r < limit_r);
  assign from_hit = (rd_entry.from_state == cur_state_r);
  assign status.scan_done = !(addr_r < limit_r) && !rd_vld_r;

  // pick the next state once the scan is over
  always_comb begin
    if (!found_r) begin
      dec_next  = fail_state_r;
      dec_cause = CAUSE_NO_MATCH;
    end else if (to_r == cur_state_r && tmo_hit_r) begin
      dec_next  = fail_state_r;
      dec_cause = CAUSE_TIMEOUT;
    end else begin
      dec_next  = to_r;
      dec_cause = CAUSE_NONE;
    end
  end

  always_comb begin
    res_item = '0;
    if (cmd.decide) begin
      res_item.state_after     = 8'(dec_next);
      res_item.initial_entered = init_flag_r;
      res_item.changed         = (dec_next != cur_state_r);
      res_item.left_state      = (dec_next != cur_state_r) ? 8'(cur_state_r) : 8'd0;
      res_item.fail_cause      = dec_cause;
    end else begin
      res_item.state_after     = 8'(cur_state_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_state_r  <= '0;
      fail_state_r  <= '0;
      entry_count_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INITIAL_STATE: init_state_r  <= STATE_WIDTH'(cfg_wdata);
        REG_FAIL_STATE:    fail_state_r  <= STATE_WIDTH'(cfg_wdata);
        REG_ENTRY_COUNT:   entry_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r  <= '0;
      entry_time_r <= '0;
      started_r    <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.load_go || cmd.decide;
      rd_vld_r    <= issue;

      if (cmd.load_go || cmd.decide) begin
        out_item_r <= res_item;
      end

      if (cmd.tick_go) begin
        code_r      <= in_item.handler_code;
        now_r       <= TIME_WIDTH'(in_item.time_now_ms);
        init_flag_r <= !started_r;
        found_r     <= 1'b0;
        tmo_hit_r   <= 1'b0;
        addr_r      <= '0;
        if (!started_r) begin
          started_r    <= 1'b1;
          cur_state_r  <= init_state_r;
          entry_time_r <= TIME_WIDTH'(in_item.time_now_ms);
        end
      end

      if (cmd.prep) begin
        elapsed_r <= now_r - entry_time_r;
        limit_r   <= (32'(entry_count_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(entry_count_r);
      end

      if (issue) begin
        addr_r <= addr_r + 1'b1;
      end

      // evaluate the entry read in the previous cycle
      if (cmd.scan && rd_vld_r) begin
        if (!found_r && from_hit && rd_entry.code == code_r) begin
          found_r <= 1'b1;
          to_r    <= rd_entry.to_state;
        end
        if (from_hit && rd_entry.timeout != '0 && elapsed_r >= rd_entry.timeout) begin
          tmo_hit_r <= 1'b1;
        end
      end

      if (cmd.decide && dec_next != cur_state_r) begin
        cur_state_r  <= dec_next;
        entry_time_r <= now_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/table_fsm_with_state_timeout.sv =====
// Table-driven state machine engine with self-loop timeout.
// Load item: strobe the cycle after accept; busy stays low; one load per idle cycle.
// Tick item: busy while the scan reads N = min(entry_count, 16) entries, one a cycle;
// result strobe in the first idle cycle; no new item is taken until busy falls.
// Synchronous active-low reset clears config to defaults, state to 0, not started.
// Depends on tfsm_pkg, tfsm_ctrl, tfsm_dp, tfsm_ram.
module table_fsm_with_state_timeout (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  tfsm_pkg::in_item_t             in_item,
  output logic                           out_valid,
  output tfsm_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [tfsm_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [tfsm_pkg::CFG_DW-1:0]    cfg_wdata
);
  import tfsm_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  tfsm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_item.opcode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  tfsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/tfsm_checker.sv =====
// Port-level checker for the state machine engine, bound to the top level.
// Depends on tfsm_pkg and table_fsm_with_state_timeout.
module tfsm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input tfsm_pkg::in_item_t   in_item,
  input logic                 out_valid,
  input tfsm_pkg::out_item_t  out_item
);
  import tfsm_pkg::*;

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode == OP_LOAD |=> out_valid)
    else $error("load item gave no result in the next cycle");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode == OP_TICK |=> busy)
    else $error("tick item did not raise busy");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("tick finished without a result");

  a_change_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.changed |-> out_item.left_state != out_item.state_after)
    else $error("change reported with equal left and new state");

endmodule

bind table_fsm_with_state_timeout tfsm_checker u_tfsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for table_fsm_with_state_timeout.
// Predicts every result from a local model of the transition engine; uses tfsm_pkg types.
// Directed cases for load, first tick, timeout, wrap and search window, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tfsm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int IDLE_CYCLES = 3;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 228;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_item_t            in_item   = '0;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_we    = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr  = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  table_fsm_with_state_timeout dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Local copy of the engine: registers, machine state and transition table.
  state_t      cfg_init    = '0;
  state_t      cfg_fail    = '0;
  logic [4:0]  cfg_count   = 5'd1;
  state_t      cur_state   = '0;
  tstamp_t     entry_time  = '0;
  bit          started     = 1'b0;
  tbl_entry_t  route_table [MAX_ENTRIES];

  out_item_t   pending_outcomes [$];
  out_item_t   want_item;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  // Random stimulus shaping
  bit          steady = 1'b0;
  tstamp_t     t_ms   = '0;
  state_t      state_pool [4];
  logic [7:0]  code_pool  [4];

  function automatic int searched_entries();
    return (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_count);
  endfunction

  function automatic out_item_t step_engine(input in_item_t it);
    out_item_t r;
    int        n;
    int        i;
    bit        found;
    state_t    nxt;
    tstamp_t   elapsed;
    r = '0;
    n = searched_entries();
    if (it.opcode == OP_LOAD) begin
      if (int'(it.slot) < MAX_ENTRIES) begin
        route_table[it.slot].from_state = it.slot_from_state;
        route_table[it.slot].code       = it.slot_code;
        route_table[it.slot].to_state   = it.slot_to_state;
        route_table[it.slot].timeout    = it.slot_timeout_ms;
      end
      r.state_after = cur_state;
      return r;
    end
    if (!started) begin
      started           = 1'b1;
      cur_state         = cfg_init;
      entry_time        = it.time_now_ms;
      r.initial_entered = 1'b1;
    end
    nxt   = cfg_fail;
    found = 1'b0;
    for (i = 0; i < n && !found; i++) begin
      if (route_table[i].from_state == cur_state && route_table[i].code == it.handler_code) begin
        nxt   = route_table[i].to_state;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.fail_cause = CAUSE_NO_MATCH;
    end else if (nxt == cur_state) begin
      elapsed = it.time_now_ms - entry_time;
      for (i = 0; i < n; i++) begin
        if (route_table[i].from_state == cur_state && route_table[i].timeout != '0 &&
            elapsed >= route_table[i].timeout) begin
          r.fail_cause = CAUSE_TIMEOUT;
          nxt          = cfg_fail;
        end
      end
    end
    if (nxt != cur_state) begin
      r.changed    = 1'b1;
      r.left_state = cur_state;
      cur_state    = nxt;
      entry_time   = it.time_now_ms;
    end
    r.state_after = cur_state;
    return r;
  endfunction

  // Result checker: every strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: state=%0h init=%0b chg=%0b left=%0h cause=%0d",
                   out_item.state_after, out_item.initial_entered, out_item.changed,
                   out_item.left_state, out_item.fail_cause);
        mismatch_count++;
      end else begin
        want_item = pending_outcomes.pop_front();
        if (out_item.state_after     !== want_item.state_after     ||
            out_item.initial_entered !== want_item.initial_entered ||
            out_item.changed         !== want_item.changed         ||
            out_item.left_state      !== want_item.left_state      ||
            out_item.fail_cause      !== want_item.fail_cause) begin
          if (mismatch_count < 10)
            $display("mismatch: expected state=%0h init=%0b chg=%0b left=%0h cause=%0d, %s",
                     want_item.state_after, want_item.initial_entered, want_item.changed,
                     want_item.left_state, want_item.fail_cause, "got:");
          if (mismatch_count < 10)
            $display("          actual   state=%0h init=%0b chg=%0b left=%0h cause=%0d",
                     out_item.state_after, out_item.initial_entered, out_item.changed,
                     out_item.left_state, out_item.fail_cause);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic in_item_t tick_item(input logic [7:0] code, input tstamp_t now);
    in_item_t it;
    it.opcode          = OP_TICK;
    it.handler_code    = code;
    it.time_now_ms     = now;
    it.slot            = 4'($urandom);
    it.slot_from_state = 8'($urandom);
    it.slot_code       = 8'($urandom);
    it.slot_to_state   = 8'($urandom);
    it.slot_timeout_ms = $urandom;
    return it;
  endfunction

  function automatic in_item_t load_item(input logic [3:0] slot, input state_t from,
                                         input logic [7:0] code, input state_t to,
                                         input tstamp_t timeout);
    in_item_t it;
    it.opcode          = OP_LOAD;
    it.handler_code    = 8'($urandom);
    it.time_now_ms     = $urandom;
    it.slot            = slot;
    it.slot_from_state = from;
    it.slot_code       = code;
    it.slot_to_state   = to;
    it.slot_timeout_ms = timeout;
    return it;
  endfunction

  // Hold the item until the engine takes it, then log its predicted outcome.
  task automatic send_item(input in_item_t it, input int gap);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_outcomes.push_back(step_engine(it));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_outcomes();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    drain_outcomes();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_INITIAL_STATE: cfg_init  = val;
      REG_FAIL_STATE:    cfg_fail  = val;
      REG_ENTRY_COUNT:   cfg_count = val[4:0];
      default: ;
    endcase
  endtask

  task automatic test_load_then_first_tick();
    write_reg(REG_INITIAL_STATE, 8'h10);
    write_reg(REG_FAIL_STATE, 8'hFF);
    write_reg(REG_ENTRY_COUNT, 8'd4);
    send_item(load_item(4'd0, 8'h10, 8'h01, 8'h20, 32'd0), pick_gap());
    send_item(load_item(4'd1, 8'h20, 8'hFF, 8'h20, 32'd5), pick_gap());
    send_item(load_item(4'd2, 8'h20, 8'h00, 8'h10, 32'd0), pick_gap());
    send_item(load_item(4'd3, 8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF), pick_gap());
    send_item(load_item(4'd15, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF), pick_gap());
    // first tick enters the initial state and moves on at once
    send_item(tick_item(8'h01, 32'hFFFF_FFF0), pick_gap());
  endtask

  task automatic test_self_loop_timeout();
    send_item(tick_item(8'hFF, 32'hFFFF_FFF2), pick_gap());
    // elapsed time wraps past zero and reaches the timeout
    send_item(tick_item(8'hFF, 32'h0000_0003), pick_gap());
  endtask

  task automatic test_fail_state_is_current();
    send_item(tick_item(8'h00, 32'd4), pick_gap());
    send_item(tick_item(8'h07, 32'd5), pick_gap());
    // elapsed of all ones meets the largest timeout
    send_item(tick_item(8'h00, 32'd2), pick_gap());
  endtask

  task automatic test_missing_transition();
    write_reg(REG_FAIL_STATE, 8'h00);
    send_item(tick_item(8'h55, 32'd0), pick_gap());
    send_item(tick_item(8'h01, 32'd1), pick_gap());
  endtask

  task automatic test_search_window();
    write_reg(REG_ENTRY_COUNT, 8'd0);
    send_item(tick_item(8'h00, 32'd10), pick_gap());
    write_reg(REG_FAIL_STATE, 8'h10);
    send_item(tick_item(8'h00, 32'd11), pick_gap());
    write_reg(REG_ENTRY_COUNT, 8'd1);
    send_item(tick_item(8'h01, 32'd20), pick_gap());
    send_item(tick_item(8'hFF, 32'd21), pick_gap());
    write_reg(REG_ENTRY_COUNT, 8'd2);
    send_item(tick_item(8'h01, 32'd30), pick_gap());
    send_item(tick_item(8'hFF, 32'd40), pick_gap());
  endtask

  function automatic state_t pool_state();
    return state_pool[$urandom_range(0, 3)];
  endfunction

  function automatic in_item_t rand_load(input logic [3:0] slot);
    state_t     from;
    state_t     to;
    logic [7:0] code;
    tstamp_t    timeout;
    int         r;
    r = $urandom_range(0, 99);
    from = (r < 45) ? cur_state : (r < 85) ? pool_state() : state_t'($urandom);
    r = $urandom_range(0, 99);
    code = (r < 85) ? code_pool[$urandom_range(0, 3)] : 8'($urandom);
    r = $urandom_range(0, 99);
    to = (r < 35) ? from : (r < 50) ? cfg_fail : (r < 90) ? pool_state() : state_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45)      timeout = '0;
    else if (r < 85) timeout = $urandom_range(1, 64);
    else if (r < 95) timeout = $urandom;
    else             timeout = '1;
    return load_item(slot, from, code, to, timeout);
  endfunction

  function automatic in_item_t rand_tick();
    logic [7:0] code;
    int         n;
    int         tries;
    int         j;
    int         r;
    n    = searched_entries();
    r    = $urandom_range(0, 99);
    code = code_pool[$urandom_range(0, 3)];
    if (r < 70 && n > 0) begin
      // steer toward a code that the current state actually handles
      for (tries = 0; tries < 8; tries++) begin
        j = $urandom_range(0, n - 1);
        if (route_table[j].from_state == cur_state) code = route_table[j].code;
      end
    end else if (r >= 90) begin
      code = 8'($urandom);
    end
    t_ms = ($urandom_range(0, 99) < 93) ? t_ms + $urandom_range(0, 8) : tstamp_t'($urandom);
    return tick_item(code, t_ms);
  endfunction

  task automatic test_random_phases();
    logic [7:0] count_setting [PHASES];
    int         p;
    int         k;
    int         r;
    count_setting = '{8'd16, 8'd3, 8'd1, 8'd17, 8'd0, 8'd31, 8'hE6, 8'd2};
    for (k = 0; k < 4; k++) begin
      state_pool[k] = state_t'($urandom);
      code_pool[k]  = 8'($urandom);
    end
    for (k = 0; k < MAX_ENTRIES; k++) send_item(rand_load(4'(k)), pick_gap());
    for (p = 0; p < PHASES; p++) begin
      for (k = 0; k < 4; k++) begin
        state_pool[k] = state_t'($urandom);
        code_pool[k]  = 8'($urandom);
      end
      state_pool[0] = cur_state;
      write_reg(REG_INITIAL_STATE, (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
      r = $urandom_range(0, 99);
      write_reg(REG_FAIL_STATE, (p == 0) ? 8'h00 : (p == 1) ? 8'hFF :
                                (r < 60) ? pool_state() : 8'($urandom));
      write_reg(REG_ENTRY_COUNT, count_setting[p]);
      steady = (p % 3 == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) drain_outcomes();
        if (r < 25) send_item(rand_load(4'($urandom)), pick_gap());
        else        send_item(rand_tick(), pick_gap());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_then_first_tick();
    test_self_loop_timeout();
    test_fail_state_is_current();
    test_missing_transition();
    test_search_window();
    test_random_phases();
    drain_outcomes();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tfsm_pkg.sv
rtl/tfsm_ram.sv
rtl/tfsm_ctrl.sv
rtl/tfsm_dp.sv
rtl/table_fsm_with_state_timeout.sv
rtl/tfsm_checker.sv
sim/testbench.sv
